// ===== rtl/md5_message_digest_assert.svh =====
// ----------------------------------------------------------------------------
// MD5 message digest assertion macros
// Concurrent property checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that post holds in the same cycle as pre.
`define MD5_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("md5 same-cycle check failed");
// Checks that post holds in the cycle after pre.
`define MD5_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("md5 next-cycle check failed");
`else
`define MD5_ASSERT_IMPLIES(label, pre, post)
`define MD5_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Transaction payload types, controller/datapath interface and MD5 constants.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUTPUT
    } md5_state_t;

    // Source of the byte written into the block buffer.
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } md5_src_t;

    typedef struct packed {
        logic     push;
        md5_src_t src;
        logic     count_byte;
        logic     start_compress;
        logic     round_en;
        logic     fold;
        logic     load_out;
    } md5_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_56;
        logic round_last;
        logic out_busy;
    } md5_sts_t;

    localparam logic [7:0] MD5_PAD_MARK = 8'h80;

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {round group, step within group of four}.
    localparam logic [4:0] MD5_ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

// ===== rtl/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte intake, padding, the 64 compression rounds and digest load.
// ----------------------------------------------------------------------------
module md5_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md5_pkg::md5_in_t  s_data,
    input  md5_pkg::md5_sts_t sts,
    output md5_pkg::md5_cmd_t cmd
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    logic       ending_reg, ending_next;
    logic       mark_done_reg, mark_done_next;
    logic       len_phase_reg, len_phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ending_reg    <= 1'b0;
            mark_done_reg <= 1'b0;
            len_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ending_reg    <= ending_next;
            mark_done_reg <= mark_done_next;
            len_phase_reg <= len_phase_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ending_next    = ending_reg;
        mark_done_next = mark_done_reg;
        len_phase_next = len_phase_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.src        = SRC_INPUT;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ending_next    = s_data.message_end;
                    mark_done_next = 1'b0;
                    len_phase_next = 1'b0;
                    if (s_data.byte_present) begin
                        cmd.push       = 1'b1;
                        cmd.count_byte = 1'b1;
                    end
                    // A byte that fills the block is compressed before any padding.
                    if (s_data.byte_present && sts.pos_last) begin
                        cmd.start_compress = 1'b1;
                        state_next         = ST_ROUND;
                    end else if (s_data.message_end) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                if (!mark_done_reg) begin
                    cmd.src = SRC_MARK;
                end else if (len_phase_reg || sts.pos_56) begin
                    cmd.src        = SRC_LEN;
                    len_phase_next = 1'b1;
                end else begin
                    cmd.src = SRC_ZERO;
                end
                mark_done_next = 1'b1;
                if (sts.pos_last) begin
                    cmd.start_compress = 1'b1;
                    state_next         = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (!ending_reg) begin
                    state_next = ST_IDLE;
                end else if (len_phase_reg) begin
                    state_next = ST_OUTPUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUTPUT: begin
                // Hold the digest until the previous one has fully drained.
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    ending_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, bit counter, one-round-per-cycle compression unit, chaining
// words and the digest output buffer.
// ----------------------------------------------------------------------------
module md5_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  md5_pkg::md5_cmd_t cmd,
    output md5_pkg::md5_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output md5_pkg::md5_out_t m_data
);
    import md5_pkg::*;

    logic [31:0] blk_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic [31:0] out_word_reg [4];
    logic [1:0]  out_idx_reg;
    logic        out_valid_reg;

    logic [7:0]  push_byte;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [31:0] b_new;

    always_comb begin
        case (cmd.src)
            SRC_MARK: push_byte = MD5_PAD_MARK;
            SRC_ZERO: push_byte = 8'h00;
            SRC_LEN:  push_byte = len_reg[{pos_reg[2:0], 3'b000} +: 8];
            default:  push_byte = in_byte;
        endcase
    end

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = rnd_reg[3:0];
            end
            2'd1: begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                g_idx = 4'(rnd_reg[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'(rnd_reg[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'(rnd_reg[3:0] * 4'd7);
            end
        endcase
        sum     = a_reg + f_val + MD5_K[rnd_reg] + blk_reg[g_idx];
        rot_dbl = {sum, sum} << MD5_ROT[{rnd_reg[5:4], rnd_reg[1:0]}];
        b_new   = b_reg + rot_dbl[63:32];
    end

    // Control and reset-initialized state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg       <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                chain_reg[k] <= MD5_IV[k];
            end
        end else begin
            if (cmd.push) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_byte) begin
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.start_compress) begin
                rnd_reg <= '0;
            end else if (cmd.round_en) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.fold) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            if (cmd.load_out) begin
                len_reg       <= '0;
                out_idx_reg   <= '0;
                out_valid_reg <= 1'b1;
                for (int k = 0; k < 4; k++) begin
                    chain_reg[k] <= MD5_IV[k];
                end
            end else if (out_valid_reg && m_ready) begin
                out_idx_reg <= out_idx_reg + 2'd1;
                if (out_idx_reg == 2'd3) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Payload storage.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            blk_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= push_byte;
        end
        if (cmd.start_compress) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (cmd.round_en) begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
        if (cmd.load_out) begin
            for (int k = 0; k < 4; k++) begin
                out_word_reg[k] <= chain_reg[k];
            end
        end
    end

    assign sts.pos_last   = (pos_reg == 6'd63);
    assign sts.pos_56     = (pos_reg == 6'd56);
    assign sts.round_last = (rnd_reg == 6'd63);
    assign sts.out_busy   = out_valid_reg;

    assign m_valid            = out_valid_reg;
    assign m_data.digest_word = out_word_reg[out_idx_reg];
    assign m_data.word_index  = out_idx_reg;
    assign m_data.last_word   = (out_idx_reg == 2'd3);

endmodule

// ===== rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 hash with internal padding and four-word digest output.
// ----------------------------------------------------------------------------
// A byte transaction that does not complete a 64-byte block leaves the
// controller idle and ready for the next one. A byte that completes a block
// is written, then runs 64 rounds in the single round unit (one round per
// clock) and adds the result into the chaining words before the next
// transaction is accepted. A message-end transaction writes the 0x80 marker,
// the zero padding and the length one byte per clock until the block ends,
// 9 to 72 bytes in all, with one or two compressions; the digest then goes
// into the output buffer once the previous digest has drained.
// The four digest words then leave one per cycle while m_ready is high, word 0
// first, while new message bytes are already accepted; a second digest waits
// only if the first has not drained yet.
module md5_message_digest (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md5_pkg::md5_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output md5_pkg::md5_out_t m_data
);
    import md5_pkg::*;

    md5_cmd_t cmd;
    md5_sts_t sts;

    md5_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    md5_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (s_data.data_byte),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`include "md5_message_digest_assert.svh"

    `MD5_ASSERT_IMPLIES(a_load_when_empty, cmd.load_out, !sts.out_busy)
    `MD5_ASSERT_IMPLIES(a_start_at_block_end, cmd.start_compress, cmd.push && sts.pos_last)
    `MD5_ASSERT_IMPLIES(a_no_intake_in_rounds, cmd.round_en, !s_ready)
    `MD5_ASSERT_NEXT(a_last_word_drains, m_valid && m_ready && m_data.last_word, !m_valid)

endmodule
